// ===== rtl/core/ebcd_pkg.sv =====
// ----------------------------------------------------------------------------
// ebcd_pkg: shared definitions for the expansion bus port
// Action codes, drive constants and the result record passed to the output.
// ----------------------------------------------------------------------------
package ebcd_pkg;

   localparam int STATUS_DEPTH = 12;

   localparam logic [2:0] COMMAND_LENGTH   = 3'd7;
   localparam logic [3:0] STATUS_REPLY_LEN = 4'd12;

   localparam logic [2:0] ACT_SELECT       = 3'd0;
   localparam logic [2:0] ACT_CMD_WRITE    = 3'd1;
   localparam logic [2:0] ACT_DATA_WRITE   = 3'd2;
   localparam logic [2:0] ACT_POLL_WRITE   = 3'd3;
   localparam logic [2:0] ACT_STATUS_READ  = 3'd4;
   localparam logic [2:0] ACT_DATA_READ    = 3'd5;
   localparam logic [2:0] ACT_POLL_READ    = 3'd6;

   localparam logic [3:0] DRIVE_SELECT     = 4'hF;
   localparam logic [7:0] CMD_GET_STATUS   = 8'h83;
   localparam logic [7:0] STATUS_FILL      = 8'h01;
   localparam logic [7:0] POLL_RESET       = 8'h0F;
   localparam logic [7:0] POLL_EMPTY       = 8'h30;
   localparam logic [7:0] LOW_NIBBLE       = 8'h0F;
   localparam logic [7:0] READY_STATUS     = 8'h10;
   localparam logic [7:0] READY_DATA       = 8'h20;
   localparam logic [7:0] MASK_STATUS      = 8'h01;
   localparam logic [7:0] MASK_DATA        = 8'h02;

   typedef struct packed {
      logic [7:0] read_value;
      logic       fiq_raised;
   } result_type;

endpackage

// ===== rtl/core/ebcd_engine.sv =====
// ----------------------------------------------------------------------------
// ebcd_engine: drive state and access decode
// Holds select, poll register, command buffer and status FIFO; works out the
// result of one transaction in the cycle it is accepted.
// ----------------------------------------------------------------------------
module ebcd_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [2:0]          action,
   input  logic [7:0]          value,
   output ebcd_pkg::result_type result
);

   logic [3:0] sel_low_ff,  sel_low_in;
   logic       sel_top_ff,  sel_top_in;
   logic [7:0] poll_ff,     poll_in;
   logic [2:0] cmd_cnt_ff,  cmd_cnt_in;
   logic [3:0] stat_cnt_ff, stat_cnt_in;
   // only the opcode byte of the command buffer is ever decoded
   logic [7:0] cmd_op_ff,   cmd_op_in;
   logic [7:0] fifo_ff [ebcd_pkg::STATUS_DEPTH];
   logic [7:0] fifo_in [ebcd_pkg::STATUS_DEPTH];

   logic       drive;
   logic [2:0] cnt_inc;
   logic [7:0] opcode;
   logic [3:0] stat_dec;

   assign drive    = (sel_low_ff == ebcd_pkg::DRIVE_SELECT);
   assign cnt_inc  = cmd_cnt_ff + 3'd1;
   assign opcode   = (cmd_cnt_ff == 3'd0) ? value : cmd_op_ff;
   assign stat_dec = stat_cnt_ff - 4'd1;

   always_comb begin
      sel_low_in  = sel_low_ff;
      sel_top_in  = sel_top_ff;
      poll_in     = poll_ff;
      cmd_cnt_in  = cmd_cnt_ff;
      stat_cnt_in = stat_cnt_ff;
      cmd_op_in   = cmd_op_ff;
      fifo_in     = fifo_ff;
      result      = '0;
      case (action)
         ebcd_pkg::ACT_SELECT: begin
            sel_low_in = value[3:0];
            sel_top_in = value[7];
         end
         ebcd_pkg::ACT_CMD_WRITE: begin
            if (drive) begin
               if (cmd_cnt_ff == 3'd0) begin
                  cmd_op_in = value;
               end
               cmd_cnt_in = cnt_inc;
               if (cnt_inc == ebcd_pkg::COMMAND_LENGTH) begin
                  cmd_cnt_in = 3'd0;
                  if (opcode == ebcd_pkg::CMD_GET_STATUS) begin
                     for (int k = 0; k < ebcd_pkg::STATUS_DEPTH; k++) begin
                        if (k == 0) begin
                           fifo_in[k] = ebcd_pkg::CMD_GET_STATUS;
                        end else if (k < int'(ebcd_pkg::STATUS_REPLY_LEN)) begin
                           fifo_in[k] = ebcd_pkg::STATUS_FILL;
                        end
                     end
                     stat_cnt_in = ebcd_pkg::STATUS_REPLY_LEN;
                     poll_in     = poll_ff | ebcd_pkg::READY_STATUS;
                  end
                  result.fiq_raised =
                     (|(poll_in & ebcd_pkg::READY_STATUS) &&
                      |(poll_in & ebcd_pkg::MASK_STATUS)) ||
                     (|(poll_in & ebcd_pkg::READY_DATA) &&
                      |(poll_in & ebcd_pkg::MASK_DATA));
               end
            end
         end
         ebcd_pkg::ACT_POLL_WRITE: begin
            if (drive) begin
               poll_in = {poll_ff[7:4], value[3:0]};
            end
         end
         ebcd_pkg::ACT_STATUS_READ: begin
            if (drive && stat_cnt_ff != 4'd0) begin
               result.read_value = fifo_ff[0];
               stat_cnt_in       = stat_dec;
               for (int k = 0; k < ebcd_pkg::STATUS_DEPTH - 1; k++) begin
                  fifo_in[k] = fifo_ff[k+1];
               end
               if (stat_dec == 4'd0) begin
                  poll_in = poll_ff & ~ebcd_pkg::READY_STATUS;
               end
            end
         end
         ebcd_pkg::ACT_POLL_READ: begin
            result.read_value = drive ? poll_ff : ebcd_pkg::POLL_EMPTY;
            if (sel_top_ff) begin
               result.read_value = result.read_value & ebcd_pkg::LOW_NIBBLE;
            end
         end
         default: begin
            // data port and unused code: no device behind them
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_low_ff  <= 4'd0;
         sel_top_ff  <= 1'b0;
         poll_ff     <= ebcd_pkg::POLL_RESET;
         cmd_cnt_ff  <= 3'd0;
         stat_cnt_ff <= 4'd0;
      end else if (accept) begin
         sel_low_ff  <= sel_low_in;
         sel_top_ff  <= sel_top_in;
         poll_ff     <= poll_in;
         cmd_cnt_ff  <= cmd_cnt_in;
         stat_cnt_ff <= stat_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_op_ff <= cmd_op_in;
         fifo_ff   <= fifo_in;
      end
   end

endmodule

// ===== rtl/core/expansion_bus_cd_port.sv =====
// ----------------------------------------------------------------------------
// expansion_bus_cd_port: expansion bus port with built-in drive at select 15
// Byte accesses for select, command, poll and status; one result per access.
// ----------------------------------------------------------------------------
//  channel  | direction | ports                               | handshake
//  req      | in        | req_action, req_value               | req_valid / req_stall
//  rsp      | out       | rsp_read_value, rsp_fiq_raised      | rsp_valid / rsp_stall
//
//  One transaction per cycle while req_stall is low; the result is registered after acceptance.
//  State is updated in the accept cycle, so back-to-back accesses see it.
//  A stalled result is held in the output register and the next result is
//  parked in a skid register; req_stall rises only when both are full.
//  Synchronous reset clears control state; the poll register resets to 0x0F.
// ----------------------------------------------------------------------------
module expansion_bus_cd_port (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_value,
   output logic       rsp_fiq_raised
);

   logic                 accept;
   logic                 take;
   ebcd_pkg::result_type result;
   ebcd_pkg::result_type out_ff;
   ebcd_pkg::result_type skid_ff;
   logic                 out_valid_ff;
   logic                 skid_valid_ff;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;

   ebcd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .action (req_action),
      .value  (req_value),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         out_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_value = out_ff.read_value;
   assign rsp_fiq_raised = out_ff.fiq_raised;

endmodule

// ===== rtl/core/ebcd_checker.sv =====
// ----------------------------------------------------------------------------
// ebcd_checker: port-level checks for the expansion bus port
// Watches the handshakes and result fields over time; bound to the top level.
// ----------------------------------------------------------------------------
module ebcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_read_value,
   input logic       rsp_fiq_raised
);

   // a held result stays on the port
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
                                 && $stable(rsp_fiq_raised))
      else $error("stalled result changed");

   // input back-pressure only follows a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall raised without a stalled result");

   // skid holds one transaction, so a free output drains it at once
   a_stall_clear: assert property (@(posedge clock) disable iff (reset)
      req_stall && !rsp_stall |=> !req_stall)
      else $error("req_stall held after result taken");

   // only a command write raises the interrupt, and writes read as zero
   a_fiq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fiq_raised |-> rsp_read_value == 8'h00)
      else $error("interrupt result carries read data");

   // nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

endmodule

bind expansion_bus_cd_port ebcd_checker u_ebcd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_value (rsp_read_value),
   .rsp_fiq_raised (rsp_fiq_raised)
);
